@@ rtl/assert_macros.svh @@
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/sle_pkg.sv @@
package sle_pkg;

   localparam int CAPACITY_DEF   = 64;
   localparam int ELEM_WIDTH_DEF = 32;

   // request word fields
   localparam int OP_W      = 3;
   localparam int INDEX_W   = 7;
   localparam int VALUE_W   = 32;
   localparam int OP_LSB    = 0;
   localparam int INDEX_LSB = OP_LSB + OP_W;
   localparam int VALUE_LSB = INDEX_LSB + INDEX_W;
   localparam int REQ_USED  = VALUE_LSB + VALUE_W;
   localparam int REQ_W     = ((REQ_USED + 7) / 8) * 8;

   // response word fields
   localparam int STATUS_W   = 2;
   localparam int READ_W     = 32;
   localparam int FOUND_W    = 6;
   localparam int LENGTH_W   = 7;
   localparam int RSP_USED   = STATUS_W + READ_W + FOUND_W + LENGTH_W;
   localparam int RSP_W      = ((RSP_USED + 7) / 8) * 8;
   localparam int RSP_PAD    = RSP_W - RSP_USED;

   localparam int MASK_W = 32;

   typedef enum logic [OP_W-1:0] {
      OP_APPEND = 3'd0,
      OP_INSERT = 3'd1,
      OP_SET    = 3'd2,
      OP_GET    = 3'd3,
      OP_FIND   = 3'd4,
      OP_REMOVE = 3'd5,
      OP_CLEAR  = 3'd6
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2,
      ST_MISS  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_SHIFT_UP,
      S_SHIFT_DOWN,
      S_SCAN,
      S_GET_DATA
   } state_type;

   typedef enum logic [1:0] {
      WALK_UP,
      WALK_DOWN,
      WALK_SCAN
   } walk_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_AT_COUNT,
      WR_AT_INDEX
   } wr_sel_type;

   typedef struct packed {
      logic       load;
      logic       walk_start;
      walk_type   walk_kind;
      logic       walk_step;
      wr_sel_type wr_sel;
      logic       rd_index;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       cnt_clear;
      logic       finish;
      status_type status;
      logic       take_read;
      logic       take_found;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   full;
      logic   idx_lt_count;
      logic   idx_le_count;
      logic   walk_busy;
      logic   match;
      logic   rsp_free;
   } stat_type;

endpackage

@@ rtl/sle_ctrl.sv @@
module sle_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output sle_pkg::cmd_type cmd,
   input  sle_pkg::stat_type stat
);
   import sle_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            // wait until the result register can take the next word
            if (stat.rsp_free) begin
               state_in = S_IDLE;
               unique case (stat.op)
                  OP_APPEND: begin
                     cmd.finish = 1'b1;
                     if (stat.full) begin
                        cmd.status = ST_FULL;
                     end else begin
                        cmd.wr_sel  = WR_AT_COUNT;
                        cmd.cnt_inc = 1'b1;
                     end
                  end
                  OP_INSERT: begin
                     if (stat.full) begin
                        cmd.finish = 1'b1;
                        cmd.status = ST_FULL;
                     end else if (!stat.idx_le_count) begin
                        cmd.finish = 1'b1;
                        cmd.status = ST_RANGE;
                     end else begin
                        cmd.walk_start = 1'b1;
                        cmd.walk_kind  = WALK_UP;
                        state_in       = S_SHIFT_UP;
                     end
                  end
                  OP_SET: begin
                     cmd.finish = 1'b1;
                     if (!stat.idx_lt_count) begin
                        cmd.status = ST_RANGE;
                     end else begin
                        cmd.wr_sel = WR_AT_INDEX;
                     end
                  end
                  OP_GET: begin
                     if (!stat.idx_lt_count) begin
                        cmd.finish = 1'b1;
                        cmd.status = ST_RANGE;
                     end else begin
                        cmd.rd_index = 1'b1;
                        state_in     = S_GET_DATA;
                     end
                  end
                  OP_FIND: begin
                     cmd.walk_start = 1'b1;
                     cmd.walk_kind  = WALK_SCAN;
                     state_in       = S_SCAN;
                  end
                  OP_REMOVE: begin
                     if (!stat.idx_lt_count) begin
                        cmd.finish = 1'b1;
                        cmd.status = ST_RANGE;
                     end else begin
                        cmd.walk_start = 1'b1;
                        cmd.walk_kind  = WALK_DOWN;
                        state_in       = S_SHIFT_DOWN;
                     end
                  end
                  OP_CLEAR: begin
                     cmd.finish    = 1'b1;
                     cmd.cnt_clear = 1'b1;
                  end
                  default: begin
                     cmd.finish = 1'b1;
                  end
               endcase
            end
         end
         S_SHIFT_UP: begin
            if (stat.walk_busy) begin
               cmd.walk_step = 1'b1;
            end else begin
               // gap is open at the index, drop the new entry in
               cmd.wr_sel  = WR_AT_INDEX;
               cmd.cnt_inc = 1'b1;
               cmd.finish  = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_SHIFT_DOWN: begin
            if (stat.walk_busy) begin
               cmd.walk_step = 1'b1;
            end else begin
               cmd.cnt_dec = 1'b1;
               cmd.finish  = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_SCAN: begin
            if (stat.match) begin
               cmd.finish     = 1'b1;
               cmd.take_found = 1'b1;
               state_in       = S_IDLE;
            end else if (!stat.walk_busy) begin
               cmd.finish = 1'b1;
               cmd.status = ST_MISS;
               state_in   = S_IDLE;
            end else begin
               cmd.walk_step = 1'b1;
            end
         end
         S_GET_DATA: begin
            cmd.finish    = 1'b1;
            cmd.take_read = 1'b1;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/sle_dp.sv @@
module sle_dp #(
   parameter int CAPACITY   = sle_pkg::CAPACITY_DEF,
   parameter int ELEM_WIDTH = sle_pkg::ELEM_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [sle_pkg::REQ_W-1:0]  req_tdata,
   input  logic                       csr_valid,
   input  logic [sle_pkg::MASK_W-1:0] csr_data,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [sle_pkg::RSP_W-1:0]  rsp_tdata,
   input  sle_pkg::cmd_type           cmd,
   output sle_pkg::stat_type          stat
);
   import sle_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = ((CW > INDEX_W) ? CW : INDEX_W) + 1;

   // list storage, single write port and registered read port
   logic [ELEM_WIDTH-1:0] mem [CAPACITY];
   logic [ELEM_WIDTH-1:0] rdata_ff;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [ELEM_WIDTH-1:0] wr_data;

   // latched request
   op_type                op_ff, op_in;
   logic [INDEX_W-1:0]    idx_ff, idx_in;
   logic [ELEM_WIDTH-1:0] val_ff, val_in;
   logic [ELEM_WIDTH-1:0] req_val;

   logic [CW-1:0]         count_ff, count_in;
   logic [MASK_W-1:0]     mask_ff, mask_in;
   logic [ELEM_WIDTH-1:0] mask_ext;

   // walk engine
   logic [AW-1:0]         ptr_ff, ptr_in;
   logic                  left_ff, left_in;
   logic                  pend_ff, pend_in;
   logic [AW-1:0]         paddr_ff, paddr_in;
   walk_type              kind_ff, kind_in;
   logic [AW-1:0]         walk_last;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            status_ff, status_in;
   logic [READ_W-1:0]     read_ff, read_in;
   logic [READ_W-1:0]     read_low;
   logic [FOUND_W-1:0]    found_ff, found_in;

   logic [XW-1:0]         cnt_x;
   logic [XW-1:0]         idx_x;
   logic [AW-1:0]         idx_a;
   logic [AW-1:0]         cnt_m1;

   always_comb begin
      req_val = '0;
      for (int b = 0; b < ELEM_WIDTH; b++) begin
         if (b < VALUE_W) begin
            req_val[b] = req_tdata[VALUE_LSB + (b % VALUE_W)];
         end
      end
   end

   // compare mask is 32 bits wide, bits above it never take part
   always_comb begin
      mask_ext = '0;
      for (int b = 0; b < ELEM_WIDTH; b++) begin
         if (b < MASK_W) begin
            mask_ext[b] = mask_ff[b % MASK_W];
         end
      end
   end

   always_comb begin
      read_low = '0;
      for (int b = 0; b < READ_W; b++) begin
         if (b < ELEM_WIDTH) begin
            read_low[b] = rdata_ff[b % ELEM_WIDTH];
         end
      end
   end

   assign cnt_x  = XW'(count_ff);
   assign idx_x  = XW'(idx_ff);
   assign idx_a  = AW'(idx_ff);
   assign cnt_m1 = AW'(count_ff - CW'(1));

   always_comb begin
      stat.op           = op_ff;
      stat.full         = (count_ff == CW'(CAPACITY));
      stat.idx_lt_count = (idx_x < cnt_x);
      stat.idx_le_count = (idx_x <= cnt_x);
      stat.walk_busy    = left_ff || pend_ff;
      stat.match        = pend_ff && (kind_ff == WALK_SCAN) &&
                          (((rdata_ff ^ val_ff) & mask_ext) == '0);
      stat.rsp_free     = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      unique case (kind_ff)
         WALK_UP: walk_last = idx_a;
         default: walk_last = cnt_m1;
      endcase
   end

   always_comb begin
      ptr_in   = ptr_ff;
      left_in  = left_ff;
      pend_in  = pend_ff;
      paddr_in = paddr_ff;
      kind_in  = kind_ff;
      rd_en    = 1'b0;
      rd_addr  = ptr_ff;
      wr_en    = 1'b0;
      wr_addr  = paddr_ff;
      wr_data  = rdata_ff;

      if (cmd.finish) begin
         left_in = 1'b0;
         pend_in = 1'b0;
      end else if (cmd.walk_start) begin
         kind_in = cmd.walk_kind;
         pend_in = 1'b0;
         unique case (cmd.walk_kind)
            WALK_UP: begin
               ptr_in  = cnt_m1;
               left_in = (idx_x < cnt_x);
            end
            WALK_DOWN: begin
               ptr_in  = idx_a + AW'(1);
               left_in = ((idx_x + XW'(1)) < cnt_x);
            end
            WALK_SCAN: begin
               ptr_in  = '0;
               left_in = (cnt_x != '0);
            end
            default: begin
               left_in = 1'b0;
            end
         endcase
      end else if (cmd.walk_step) begin
         pend_in  = left_ff;
         paddr_in = ptr_ff;
         if (left_ff) begin
            rd_en = 1'b1;
            if (ptr_ff == walk_last) begin
               left_in = 1'b0;
            end else if (kind_ff == WALK_UP) begin
               ptr_in = ptr_ff - AW'(1);
            end else begin
               ptr_in = ptr_ff + AW'(1);
            end
         end
         // entry read last cycle moves one place along
         if (pend_ff && (kind_ff != WALK_SCAN)) begin
            wr_en   = 1'b1;
            wr_addr = (kind_ff == WALK_UP) ? paddr_ff + AW'(1) : paddr_ff - AW'(1);
         end
      end

      unique case (cmd.wr_sel)
         WR_AT_COUNT: begin
            wr_en   = 1'b1;
            wr_addr = AW'(count_ff);
            wr_data = val_ff;
         end
         WR_AT_INDEX: begin
            wr_en   = 1'b1;
            wr_addr = idx_a;
            wr_data = val_ff;
         end
         default: begin
         end
      endcase

      if (cmd.rd_index) begin
         rd_en   = 1'b1;
         rd_addr = idx_a;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      op_in  = op_ff;
      idx_in = idx_ff;
      val_in = val_ff;
      if (cmd.load) begin
         op_in  = op_type'(req_tdata[OP_LSB +: OP_W]);
         idx_in = req_tdata[INDEX_LSB +: INDEX_W];
         val_in = req_val;
      end

      count_in = count_ff;
      if (cmd.cnt_clear) begin
         count_in = '0;
      end else if (cmd.cnt_inc) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CW'(1);
      end

      mask_in = csr_valid ? csr_data : mask_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      status_in    = status_ff;
      read_in      = read_ff;
      found_in     = found_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         status_in    = cmd.status;
         read_in      = cmd.take_read ? read_low : '0;
         found_in     = cmd.take_found ? FOUND_W'(paddr_ff) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         mask_ff      <= '1;
         left_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         mask_ff      <= mask_in;
         left_ff      <= left_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      idx_ff    <= idx_in;
      val_ff    <= val_in;
      ptr_ff    <= ptr_in;
      paddr_ff  <= paddr_in;
      kind_ff   <= kind_in;
      status_ff <= status_in;
      read_ff   <= read_in;
      found_ff  <= found_in;
   end

   // length is live: count cannot move while a word waits
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD{1'b0}}, LENGTH_W'(count_ff), found_ff, read_ff, status_ff};

endmodule

@@ rtl/sequential_list_engine.sv @@
// channel    direction  handshake                fields
// req        in         req_tvalid/req_tready    operation, index, value
// rsp        out        rsp_tvalid/rsp_tready    status, read_value, found_index, length
// csr        in         csr_valid/csr_ready      match_mask
//
// one item at a time: a new request is accepted only once the last one has finished
// append, set, clear and rejected items finish at dispatch, get reads the entry first
// insert moves the entries from the index up one place, remove moves those above it down
// find scans from position 0 and stops at the first hit or at the end of the list
// synchronous reset empties the list and sets the mask to all ones
// a waiting result word holds dispatch of the next item until it is taken

`include "assert_macros.svh"

module sequential_list_engine #(
   parameter int CAPACITY   = sle_pkg::CAPACITY_DEF,
   parameter int ELEM_WIDTH = sle_pkg::ELEM_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [sle_pkg::REQ_W-1:0]  req_tdata,   // operation, index, value, zero pad
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [sle_pkg::MASK_W-1:0] csr_data,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [sle_pkg::RSP_W-1:0]  rsp_tdata    // status, read_value, found_index, length, pad
);
   import sle_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   sle_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   sle_dp #(
      .CAPACITY   (CAPACITY),
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .stat       (stat)
   );

   `ASSERT_IMPLIES(a_finish_slot_free, clock, reset, cmd.finish, stat.rsp_free, "result word overwritten")
   `ASSERT_IMPLIES(a_no_grow_full, clock, reset, cmd.cnt_inc, !stat.full, "count grew past capacity")
   `ASSERT_NEXT(a_one_item, clock, reset, req_tvalid && req_tready, !req_tready, "second item taken while busy")

endmodule

@@ test/tb.sv @@
module tb;
   import sle_pkg::*;

   localparam int SLOTS = CAPACITY_DEF;
   localparam int SLOT_AW = $clog2(SLOTS);
   localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
   localparam int READ_LSB   = STATUS_W;
   localparam int FOUND_LSB  = READ_LSB + READ_W;
   localparam int LENGTH_LSB = FOUND_LSB + FOUND_W;
   localparam int DRAIN_CYCLES = 100;

   typedef enum {MIX_GROW, MIX_FULL, MIX_BALANCED, MIX_SHRINK} mix_type;

   typedef struct packed {
      status_type          status;
      logic [READ_W-1:0]   read_value;
      logic [FOUND_W-1:0]  found_index;
      logic [LENGTH_W-1:0] length;
   } list_result_type;

   // shadow copy of the list and the mask, with the results still owed
   class list_mirror;
      logic [VALUE_W-1:0] slots [SLOTS];
      int                 fill;
      logic [MASK_W-1:0]  mask;
      list_result_type    pending_results [$];
      int                 errors;

      function new();
         fill = 0;
         mask = '1;
         errors = 0;
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [INDEX_W-1:0] idx,
                                 logic [VALUE_W-1:0] val);
         list_result_type r;
         int pos;
         r.status = ST_OK;
         r.read_value = '0;
         r.found_index = '0;
         case (op)
            OP_APPEND: begin
               if (fill >= SLOTS) begin
                  r.status = ST_FULL;
               end else begin
                  slots[SLOT_AW'(fill)] = val;
                  fill++;
               end
            end
            OP_INSERT: begin
               // full is checked ahead of the index
               if (fill >= SLOTS) begin
                  r.status = ST_FULL;
               end else if (int'(idx) > fill) begin
                  r.status = ST_RANGE;
               end else begin
                  for (pos = fill; pos > int'(idx); pos--)
                     slots[SLOT_AW'(pos)] = slots[SLOT_AW'(pos - 1)];
                  slots[SLOT_AW'(idx)] = val;
                  fill++;
               end
            end
            OP_SET: begin
               if (int'(idx) >= fill) r.status = ST_RANGE;
               else slots[SLOT_AW'(idx)] = val;
            end
            OP_GET: begin
               if (int'(idx) >= fill) r.status = ST_RANGE;
               else r.read_value = slots[SLOT_AW'(idx)];
            end
            OP_FIND: begin
               r.status = ST_MISS;
               for (pos = 0; pos < fill; pos++) begin
                  if (((slots[SLOT_AW'(pos)] ^ val) & mask) == '0) begin
                     r.status = ST_OK;
                     r.found_index = FOUND_W'(pos);
                     break;
                  end
               end
            end
            OP_REMOVE: begin
               if (int'(idx) >= fill) begin
                  r.status = ST_RANGE;
               end else begin
                  for (pos = int'(idx); pos + 1 < fill; pos++)
                     slots[SLOT_AW'(pos)] = slots[SLOT_AW'(pos + 1)];
                  fill--;
               end
            end
            OP_CLEAR: fill = 0;
            default: ;
         endcase
         r.length = LENGTH_W'(fill);
         pending_results.push_back(r);
      endfunction

      function void check_response(logic [RSP_W-1:0] word);
         list_result_type want;
         logic [STATUS_W-1:0] got_status;
         logic [READ_W-1:0]   got_read;
         logic [FOUND_W-1:0]  got_found;
         logic [LENGTH_W-1:0] got_length;
         got_status = word[STATUS_W-1:0];
         got_read   = word[READ_LSB +: READ_W];
         got_found  = word[FOUND_LSB +: FOUND_W];
         got_length = word[LENGTH_LSB +: LENGTH_W];
         if (pending_results.size() == 0) begin
            $error("result word with nothing expected: %h", word);
            errors++;
            return;
         end
         want = pending_results.pop_front();
         if (got_status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got_status);
            errors++;
         end
         if (got_read !== want.read_value) begin
            $error("read_value: expected %h, actual %h", want.read_value, got_read);
            errors++;
         end
         if (got_found !== want.found_index) begin
            $error("found_index: expected %0d, actual %0d", want.found_index, got_found);
            errors++;
         end
         if (got_length !== want.length) begin
            $error("length: expected %0d, actual %0d", want.length, got_length);
            errors++;
         end
      endfunction
   endclass

   logic              clock;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata = '0;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [MASK_W-1:0] csr_data = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;

   list_mirror mirror;
   bit         steady = 1'b0;

   sequential_list_engine DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("tb: errors");
      $finish;
   end

   function automatic logic [OP_W-1:0] pick_op(mix_type mix);
      int r;
      r = $urandom_range(0, 99);
      case (mix)
         MIX_GROW: begin
            if (r < 65) return OP_APPEND;
            if (r < 85) return OP_INSERT;
            if (r < 90) return OP_SET;
            if (r < 94) return OP_GET;
            if (r < 98) return OP_FIND;
            return OP_UNUSED;
         end
         MIX_FULL: begin
            if (r < 30) return OP_APPEND;
            if (r < 55) return OP_INSERT;
            if (r < 70) return OP_SET;
            if (r < 80) return OP_GET;
            if (r < 95) return OP_FIND;
            return OP_REMOVE;
         end
         MIX_SHRINK: begin
            if (r < 60) return OP_REMOVE;
            if (r < 70) return OP_INSERT;
            if (r < 80) return OP_GET;
            if (r < 90) return OP_FIND;
            if (r < 95) return OP_SET;
            return OP_CLEAR;
         end
         default: begin
            if (r < 18) return OP_APPEND;
            if (r < 36) return OP_INSERT;
            if (r < 50) return OP_SET;
            if (r < 64) return OP_GET;
            if (r < 80) return OP_FIND;
            if (r < 94) return OP_REMOVE;
            if (r < 97) return OP_CLEAR;
            return OP_UNUSED;
         end
      endcase
   endfunction

   function automatic logic [INDEX_W-1:0] pick_index();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return INDEX_W'($urandom_range(0, mirror.fill));
      if (r < 90) return INDEX_W'(SLOTS);
      return INDEX_W'($urandom_range(0, SLOTS));
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      // keys near stored entries so find hits, differing only in masked-off bits
      if (r < 35 && mirror.fill > 0) begin
         return mirror.slots[SLOT_AW'($urandom_range(0, mirror.fill - 1))] ^
                ($urandom() & ~mirror.mask);
      end
      if (r < 50) begin
         case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            2: return 32'h8000_0000;
            default: return 32'h0000_0001;
         endcase
      end
      return $urandom();
   endfunction

   task automatic send_request(logic [OP_W-1:0] op, logic [INDEX_W-1:0] idx,
                               logic [VALUE_W-1:0] val);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= REQ_W'({val, idx, op});
      do @(posedge clock); while (!req_tready);
      mirror.note_request(op, idx, val);
   endtask

   task automatic send_random(mix_type mix);
      logic [OP_W-1:0] op;
      op = pick_op(mix);
      send_request(op, pick_index(), pick_value());
   endtask

   task automatic write_mask(logic [MASK_W-1:0] m);
      csr_valid <= 1'b1;
      csr_data <= m;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      mirror.mask = m;
   endtask

   // let every owed word arrive, then give the walk time to finish
   task automatic settle();
      req_tvalid <= 1'b0;
      while (mirror.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 11);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         mirror.check_response(rsp_tdata);
      end
   end

   initial begin
      logic [MASK_W-1:0] masks [6];
      int issued;
      mirror = new();
      masks = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_FFFF, 32'hFFFF_0000, 0, 0};
      masks[4] = $urandom();
      masks[5] = $urandom();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_mask(32'hFFFF_FFFF);

      // empty list
      send_request(OP_GET, 7'd0, 32'h0);
      send_request(OP_FIND, 7'd0, 32'h0);
      send_request(OP_REMOVE, 7'd0, 32'h0);
      send_request(OP_SET, 7'd0, 32'h1);
      send_request(OP_INSERT, 7'd1, 32'h2);
      // building up, insert at count acts as append
      send_request(OP_INSERT, 7'd0, 32'hFFFF_FFFF);
      send_request(OP_APPEND, 7'd0, 32'h0000_0000);
      send_request(OP_APPEND, 7'd0, 32'h8000_0001);
      send_request(OP_INSERT, 7'd3, 32'h1234_5678);
      send_request(OP_INSERT, 7'd1, 32'hA5A5_A5A5);
      send_request(OP_GET, 7'd1, 32'h0);
      send_request(OP_GET, 7'd4, 32'h0);
      send_request(OP_GET, 7'd5, 32'h0);
      send_request(OP_SET, 7'd4, 32'h5A5A_5A5A);
      send_request(OP_FIND, 7'd0, 32'h0000_0000);
      send_request(OP_FIND, 7'd0, 32'hDEAD_BEEF);
      send_request(OP_REMOVE, 7'd0, 32'h0);
      send_request(OP_REMOVE, 7'd3, 32'h0);
      send_request(OP_UNUSED, 7'd64, 32'hFFFF_FFFF);
      send_request(OP_GET, 7'd64, 32'h0);
      send_request(OP_CLEAR, 7'd0, 32'h0);
      send_request(OP_GET, 7'd0, 32'h0);
      settle();

      foreach (masks[p]) begin
         write_mask(masks[p]);
         issued = 0;
         steady = ($urandom_range(0, 3) == 0);
         while (mirror.fill < SLOTS && issued < 110) begin
            send_random(MIX_GROW);
            issued++;
         end
         repeat (12) begin
            send_random(MIX_FULL);
            issued++;
         end
         while (issued < 135) begin
            if (issued % 30 == 0) steady = ($urandom_range(0, 3) == 0);
            send_random((issued % 45) < 15 ? MIX_SHRINK : MIX_BALANCED);
            issued++;
         end
         steady = 1'b0;
         settle();
      end

      if (mirror.errors == 0 && mirror.pending_results.size() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end
endmodule
